@@ hdl/sgm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants for the per-channel spike/gap marker.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int NUM_CHANNELS_DEF = 256;
  localparam int CH_W             = 8;
  localparam int TIME_W           = 64;
  localparam int POS_W            = 32;
  localparam int CNT_W            = 32;
  localparam int EV_W             = 8;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes (paddr[2])
  localparam logic REG_SKIP_FLOOR = 1'b0;
  localparam logic REG_EXEMPT     = 1'b1;

  localparam logic [EV_W-1:0] EV_RESET = 8'hFF;

  typedef struct packed {
    logic [EV_W-1:0]   event_code;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] time_value;
    logic [POS_W-1:0]  record_position;
    logic              end_of_trace;
  } sgm_in_t;

  typedef struct packed {
    logic              mark_valid;
    logic [POS_W-1:0]  bad_position;
    logic              was_skipped;
    logic [CNT_W-1:0]  outlier_count;
  } sgm_out_t;

  typedef struct packed {
    logic [EV_W-1:0] skip_event_floor;
    logic [EV_W-1:0] exempt_event;
  } sgm_cfg_t;

  // older_valid is only meaningful while the channel's middle valid flag is set
  typedef struct packed {
    logic              older_valid;
    logic [TIME_W-1:0] older_time;
    logic [TIME_W-1:0] middle_time;
    logic [POS_W-1:0]  middle_position;
  } sgm_hist_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    sgm_hist_t       data;
  } sgm_wr_t;

endpackage

@@ hdl/sgm_cfg.sv @@
// ----------------------------------------------------------------------------
// sgm_cfg
// APB register file: skip event floor and exempt event code.
// ----------------------------------------------------------------------------
module sgm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sgm_pkg::APB_AW-1:0]   paddr,
  input  logic [sgm_pkg::APB_DW-1:0]   pwdata,
  output logic [sgm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output sgm_pkg::sgm_cfg_t            cfg
);

  sgm_pkg::sgm_cfg_t cfg_r;
  sgm_pkg::sgm_cfg_t cfg_nxt;
  logic              reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        sgm_pkg::REG_SKIP_FLOOR: cfg_nxt.skip_event_floor = pwdata[sgm_pkg::EV_W-1:0];
        sgm_pkg::REG_EXEMPT:     cfg_nxt.exempt_event     = pwdata[sgm_pkg::EV_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sgm_pkg::REG_SKIP_FLOOR: prdata = {{(sgm_pkg::APB_DW-sgm_pkg::EV_W){1'b0}},
                                         cfg_r.skip_event_floor};
      sgm_pkg::REG_EXEMPT:     prdata = {{(sgm_pkg::APB_DW-sgm_pkg::EV_W){1'b0}},
                                         cfg_r.exempt_event};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_event_floor <= sgm_pkg::EV_RESET;
      cfg_r.exempt_event     <= sgm_pkg::EV_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/sgm_mem.sv @@
// ----------------------------------------------------------------------------
// sgm_mem
// Per-channel history RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgm_mem #(
  parameter int NUM_CHANNELS = sgm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [sgm_pkg::CH_W-1:0]   rd_addr,
  output sgm_pkg::sgm_hist_t         rd_data,
  input  sgm_pkg::sgm_wr_t           wr
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  sgm_pkg::sgm_hist_t hist_mem [NUM_CHANNELS];
  sgm_pkg::sgm_hist_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      hist_mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr[IDX_W-1:0]];
    end
  end

endmodule

@@ hdl/sgm_core.sv @@
// ----------------------------------------------------------------------------
// sgm_core
// Check stage: valid bits, write forwarding, spike/gap test, outlier count,
// result register.
// ----------------------------------------------------------------------------
module sgm_core #(
  parameter int NUM_CHANNELS = sgm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sgm_pkg::sgm_cfg_t   cfg,
  input  logic                s1_valid,
  input  sgm_pkg::sgm_in_t    s1_item,
  input  sgm_pkg::sgm_hist_t  rd_data,
  output logic                s1_advance,
  output sgm_pkg::sgm_wr_t    wr,
  output logic                out_valid,
  input  logic                out_stall,
  output sgm_pkg::sgm_out_t   out_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [sgm_pkg::CH_W:0] NCH = (sgm_pkg::CH_W+1)'(NUM_CHANNELS);

  logic [NUM_CHANNELS-1:0]       middle_valid_r;
  logic                          fwd_valid_r;
  logic [sgm_pkg::CH_W-1:0]      fwd_ch_r;
  sgm_pkg::sgm_hist_t            fwd_data_r;
  logic [sgm_pkg::CNT_W-1:0]     count_r;
  logic [sgm_pkg::CNT_W-1:0]     count_nxt;
  logic                          out_valid_r;
  sgm_pkg::sgm_out_t             out_data_r;

  logic                          ch_ok;
  logic                          skipped;
  logic [IDX_W-1:0]              idx;
  logic                          ov;
  logic                          mv;
  sgm_pkg::sgm_hist_t            hist;
  logic [sgm_pkg::TIME_W-1:0]    p_t;
  logic [sgm_pkg::TIME_W-1:0]    m_t;
  logic [sgm_pkg::TIME_W-1:0]    n_t;
  logic                          outlier;
  sgm_pkg::sgm_hist_t            hist_nxt;

  assign s1_advance = s1_valid && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign ch_ok    = {1'b0, s1_item.channel} < NCH;
  assign skipped  = (s1_item.event_code >= cfg.skip_event_floor)
                 || (s1_item.event_code == cfg.exempt_event) || !ch_ok;
  assign idx      = s1_item.channel[IDX_W-1:0];

  // last write may not be visible in the registered read yet
  assign hist = (fwd_valid_r && fwd_ch_r == s1_item.channel) ? fwd_data_r : rd_data;
  assign mv   = ch_ok && middle_valid_r[idx];
  assign ov   = mv && hist.older_valid;
  assign p_t  = hist.older_time;
  assign m_t  = hist.middle_time;
  assign n_t  = s1_item.time_value;

  assign outlier = ov && mv && (p_t < n_t)
                && (((p_t < m_t) && (m_t >= n_t)) || ((p_t >= m_t) && (m_t < n_t)))
                && !skipped;

  always_comb begin
    hist_nxt.older_valid     = outlier ? ov : mv;
    hist_nxt.older_time      = outlier ? p_t : m_t;
    hist_nxt.middle_time     = n_t;
    hist_nxt.middle_position = s1_item.record_position;
  end

  always_comb begin
    count_nxt = count_r;
    if (outlier && count_r != sgm_pkg::CNT_MAX) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    wr.en   = s1_advance && !skipped;
    wr.addr = s1_item.channel;
    wr.data = hist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      middle_valid_r <= '0;
    end else if (s1_advance) begin
      if (s1_item.end_of_trace) begin
        middle_valid_r <= '0;
      end else if (!skipped) begin
        middle_valid_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_advance) begin
        fwd_valid_r <= !skipped;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      fwd_ch_r                 <= s1_item.channel;
      fwd_data_r               <= hist_nxt;
      out_data_r.mark_valid    <= outlier;
      out_data_r.bad_position  <= outlier ? hist.middle_position : '0;
      out_data_r.was_skipped   <= skipped;
      out_data_r.outlier_count <= count_nxt;
    end
  end

endmodule

@@ hdl/per_channel_spike_gap_marker.sv @@
// ----------------------------------------------------------------------------
// per_channel_spike_gap_marker
// Flags spike/gap timestamps per channel in a stream of trace records.
// ----------------------------------------------------------------------------
// One record is taken every clock cycle while the result channel is not
// stalled. A record waits in the input register, then its result in the result
// register until it transfers. The rate is set by the per-channel history RAM:
// one read when a record is taken, one write of the updated entry when it
// leaves the input register, with the last write forwarded so that back-to-back
// records on the same channel see fresh history. Each channel's middle-sample
// valid bit is a flip-flop and the older sample's flag is in the RAM entry, so
// reset and the end-of-trace mark clear all history at once without a sweep.
module per_channel_spike_gap_marker #(
  parameter int NUM_CHANNELS = sgm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sgm_pkg::sgm_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sgm_pkg::sgm_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sgm_pkg::APB_AW-1:0]   paddr,
  input  logic [sgm_pkg::APB_DW-1:0]   pwdata,
  output logic [sgm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  sgm_pkg::sgm_cfg_t  cfg;
  sgm_pkg::sgm_hist_t rd_data;
  sgm_pkg::sgm_wr_t   wr;
  sgm_pkg::sgm_in_t   s1_item_r;
  logic               s1_valid_r;
  logic               s1_advance;
  logic               in_xfer;

  assign in_stall = s1_valid_r && !s1_advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
  end

  sgm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgm_mem #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (in_data.channel),
    .rd_data (rd_data),
    .wr      (wr)
  );

  sgm_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid_r),
    .s1_item    (s1_item_r),
    .rd_data    (rd_data),
    .s1_advance (s1_advance),
    .wr         (wr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ hdl/sgm_checker.sv @@
// ----------------------------------------------------------------------------
// sgm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sgm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input sgm_pkg::sgm_out_t out_data
);

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_mark_not_skipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mark_valid |-> !out_data.was_skipped)
    else $error("mark on a skipped record");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mark_valid |-> out_data.bad_position == '0)
    else $error("bad_position set without mark");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n)
      |-> out_data.outlier_count >= $past(out_data.outlier_count))
    else $error("outlier count went down");

endmodule

bind per_channel_spike_gap_marker sgm_checker u_sgm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/sv/sgm_mark_checker.sv @@
// ----------------------------------------------------------------------------
// sgm_mark_checker
// Watches the record, result and register ports of the spike/gap marker,
// keeps its own per-channel history to predict each result, and compares
// every result transfer field by field against the oldest prediction.
// Register writes are tracked and register reads are checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_mark_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  sgm_pkg::sgm_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  sgm_pkg::sgm_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sgm_pkg::APB_AW-1:0] paddr,
  input  logic [sgm_pkg::APB_DW-1:0] pwdata,
  input  logic [sgm_pkg::APB_DW-1:0] prdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending,
  output int                         records,
  output int                         marks,
  output int                         skips
);

  localparam int NCH = sgm_pkg::NUM_CHANNELS_DEF;

  logic [sgm_pkg::TIME_W-1:0] older_ts [NCH];
  logic                       older_ok [NCH];
  logic [sgm_pkg::TIME_W-1:0] mid_ts   [NCH];
  logic [sgm_pkg::POS_W-1:0]  mid_pos  [NCH];
  logic                       mid_ok   [NCH];
  logic [sgm_pkg::CNT_W-1:0]  outlier_total;
  logic [sgm_pkg::EV_W-1:0]   skip_floor;
  logic [sgm_pkg::EV_W-1:0]   exempt_ev;

  sgm_pkg::sgm_out_t expected_marks [$];
  int err_n  = 0;
  int rec_n  = 0;
  int mark_n = 0;
  int skip_n = 0;

  function automatic void clear_history();
    for (int i = 0; i < NCH; i++) begin
      older_ts[i] = '0;
      older_ok[i] = 1'b0;
      mid_ts[i]   = '0;
      mid_pos[i]  = '0;
      mid_ok[i]   = 1'b0;
    end
  endfunction

  function automatic sgm_pkg::sgm_out_t judge_record(input sgm_pkg::sgm_in_t r);
    sgm_pkg::sgm_out_t          res;
    logic                       outlier;
    logic [sgm_pkg::TIME_W-1:0] p;
    logic [sgm_pkg::TIME_W-1:0] m;
    int                         c;
    res     = '0;
    outlier = 1'b0;
    c       = r.channel;
    res.was_skipped = (r.event_code >= skip_floor) || (r.event_code == exempt_ev)
                      || (c >= NCH);
    if (!res.was_skipped) begin
      if (older_ok[c] && mid_ok[c]) begin
        p = older_ts[c];
        m = mid_ts[c];
        outlier = (p < r.time_value) &&
                  ((p < m && m >= r.time_value) || (p >= m && m < r.time_value));
      end
      if (outlier) begin
        res.mark_valid   = 1'b1;
        res.bad_position = mid_pos[c];
        if (outlier_total != sgm_pkg::CNT_MAX)
          outlier_total = outlier_total + 1'b1;
      end else begin
        older_ts[c] = mid_ts[c];
        older_ok[c] = mid_ok[c];
      end
      mid_ts[c]  = r.time_value;
      mid_pos[c] = r.record_position;
      mid_ok[c]  = 1'b1;
    end
    if (r.end_of_trace)
      clear_history();
    res.outlier_count = outlier_total;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_n++;
      $display("%t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    sgm_pkg::sgm_out_t          want;
    logic [sgm_pkg::APB_DW-1:0] reg_val;
    if (!rst_n) begin
      clear_history();
      outlier_total = '0;
      skip_floor    = sgm_pkg::EV_RESET;
      exempt_ev     = sgm_pkg::EV_RESET;
      expected_marks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_marks.size() == 0) begin
          err_n++;
          $display("%t: unexpected result transfer, expected none actual %h",
                   $time, out_data);
        end else begin
          want = expected_marks.pop_front();
          check_field("mark_valid", want.mark_valid, out_data.mark_valid);
          check_field("bad_position", want.bad_position, out_data.bad_position);
          check_field("was_skipped", want.was_skipped, out_data.was_skipped);
          check_field("outlier_count", want.outlier_count, out_data.outlier_count);
        end
      end
      if (in_valid && !in_stall) begin
        want = judge_record(in_data);
        expected_marks.push_back(want);
        rec_n++;
        if (want.mark_valid)
          mark_n++;
        if (want.was_skipped)
          skip_n++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == sgm_pkg::REG_SKIP_FLOOR)
            skip_floor = pwdata[sgm_pkg::EV_W-1:0];
          else
            exempt_ev = pwdata[sgm_pkg::EV_W-1:0];
        end else begin
          reg_val = '0;
          if (paddr[2] == sgm_pkg::REG_SKIP_FLOOR)
            reg_val[sgm_pkg::EV_W-1:0] = skip_floor;
          else
            reg_val[sgm_pkg::EV_W-1:0] = exempt_ev;
          check_field("register read", reg_val, prdata);
        end
      end
    end
    errors  <= err_n;
    pending <= expected_marks.size();
    records <= rec_n;
    marks   <= mark_n;
    skips   <= skip_n;
  end

endmodule

@@ tb/sv/per_channel_spike_gap_marker_test.sv @@
// ----------------------------------------------------------------------------
// per_channel_spike_gap_marker_test
// Drives trace records and filter settings into the spike/gap marker and
// randomly stalls its result channel. Directed records cover spikes, gaps,
// ties, short histories, skipped and exempt events and end marks; random
// phases under several filter settings follow. Checking is in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_channel_spike_gap_marker_test;

  localparam int CYCLE_LIMIT = 300000;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  sgm_pkg::sgm_in_t           in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  sgm_pkg::sgm_out_t          out_data;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [sgm_pkg::APB_AW-1:0] paddr     = '0;
  logic [sgm_pkg::APB_DW-1:0] pwdata    = '0;
  logic [sgm_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  int errors, pending, records, marks, skips;

  bit                         quiet      = 1'b0;
  int                         stall_left = 0;
  int                         cycle_n    = 0;
  logic [sgm_pkg::TIME_W-1:0] ramp [sgm_pkg::NUM_CHANNELS_DEF];

  per_channel_spike_gap_marker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sgm_mark_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .pending(pending), .records(records),
    .marks(marks), .skips(skips)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short runs, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(0, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 99) < 35);
      stall_left <= idle_len();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic sgm_pkg::sgm_in_t rec(input logic [sgm_pkg::EV_W-1:0] ev,
                                           input logic [sgm_pkg::CH_W-1:0] ch,
                                           input logic [sgm_pkg::TIME_W-1:0] t,
                                           input logic [sgm_pkg::POS_W-1:0] pos,
                                           input logic last);
    sgm_pkg::sgm_in_t r;
    r.event_code      = ev;
    r.channel         = ch;
    r.time_value      = t;
    r.record_position = pos;
    r.end_of_trace    = last;
    return r;
  endfunction

  // steady ramps per channel with injected spikes, gaps and wild times
  function automatic sgm_pkg::sgm_in_t random_record();
    sgm_pkg::sgm_in_t           r;
    int                         k;
    int                         c;
    logic [sgm_pkg::TIME_W-1:0] jump;
    k = $urandom_range(0, 99);
    c = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    r.event_code = ($urandom_range(0, 99) < 85)
                   ? sgm_pkg::EV_W'($urandom_range(0, 15))
                   : sgm_pkg::EV_W'($urandom_range(0, 255));
    r.channel         = sgm_pkg::CH_W'(c);
    r.record_position = $urandom();
    r.end_of_trace    = ($urandom_range(0, 59) == 0);
    jump = sgm_pkg::TIME_W'($urandom_range(1000, 100000));
    if (k < 12)
      r.time_value = ramp[c] + jump;
    else if (k < 24)
      r.time_value = ramp[c] - jump;
    else if (k < 28)
      r.time_value = {$urandom(), $urandom()};
    else begin
      ramp[c] = ramp[c] + sgm_pkg::TIME_W'($urandom_range(1, 500));
      r.time_value = ramp[c];
    end
    return r;
  endfunction

  task automatic send_record(input sgm_pkg::sgm_in_t r);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic idx,
                            input logic [sgm_pkg::EV_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(sgm_pkg::APB_DW-sgm_pkg::EV_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filters(input logic [sgm_pkg::EV_W-1:0] floor_v,
                             input logic [sgm_pkg::EV_W-1:0] exempt_v);
    cfg_access(1'b1, sgm_pkg::REG_SKIP_FLOOR, floor_v);
    cfg_access(1'b1, sgm_pkg::REG_EXEMPT, exempt_v);
    cfg_access(1'b0, sgm_pkg::REG_SKIP_FLOOR, '0);
    cfg_access(1'b0, sgm_pkg::REG_EXEMPT, '0);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++)
      send_record(random_record());
  endtask

  initial begin
    for (int i = 0; i < sgm_pkg::NUM_CHANNELS_DEF; i++)
      ramp[i] = {1'b0, $urandom(), 31'($urandom())};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values read back, then written explicitly
    cfg_access(1'b0, sgm_pkg::REG_SKIP_FLOOR, '0);
    cfg_access(1'b0, sgm_pkg::REG_EXEMPT, '0);
    set_filters(8'd255, 8'd255);

    // spike, then gap, then a plain rise, then older above new
    send_record(rec(8'd0, 8'd0, 64'd10, 32'd1, 1'b0));
    send_record(rec(8'd1, 8'd0, 64'd20, 32'd2, 1'b0));
    send_record(rec(8'd2, 8'd0, 64'd15, 32'd3, 1'b0));
    send_record(rec(8'd3, 8'd1, 64'd10, 32'd4, 1'b0));
    send_record(rec(8'd3, 8'd1, 64'd5, 32'd5, 1'b0));
    send_record(rec(8'd3, 8'd1, 64'd20, 32'd6, 1'b0));
    send_record(rec(8'd4, 8'd2, 64'd100, 32'd7, 1'b0));
    send_record(rec(8'd4, 8'd2, 64'd200, 32'd8, 1'b0));
    send_record(rec(8'd4, 8'd2, 64'd300, 32'd9, 1'b0));
    send_record(rec(8'd5, 8'd3, 64'd40, 32'd10, 1'b0));
    send_record(rec(8'd5, 8'd3, 64'd50, 32'd11, 1'b0));
    send_record(rec(8'd5, 8'd3, 64'd30, 32'd12, 1'b0));
    // ties: middle equal to new, older equal to middle
    send_record(rec(8'd6, 8'd4, 64'd5, 32'd13, 1'b0));
    send_record(rec(8'd6, 8'd4, 64'd9, 32'd14, 1'b0));
    send_record(rec(8'd6, 8'd4, 64'd9, 32'd15, 1'b0));
    send_record(rec(8'd7, 8'd5, 64'd7, 32'd16, 1'b0));
    send_record(rec(8'd7, 8'd5, 64'd7, 32'd17, 1'b0));
    send_record(rec(8'd7, 8'd5, 64'd8, 32'd18, 1'b0));
    // field extremes, then a skipped record carrying the end mark
    send_record(rec(8'd254, 8'd255, '1, '1, 1'b0));
    send_record(rec(8'd254, 8'd255, '0, '0, 1'b0));
    send_record(rec(8'd255, 8'd7, 64'd0, 32'h8000_0000, 1'b1));
    // history gone: two records build it up again before a gap shows
    send_record(rec(8'd0, 8'd0, 64'd50, 32'd19, 1'b0));
    send_record(rec(8'd0, 8'd0, 64'd10, 32'd20, 1'b0));
    send_record(rec(8'd0, 8'd0, 64'd100, 32'd21, 1'b0));
    send_record(rec(8'h80, 8'hAA, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b1));
    drain();

    set_filters(8'd200, 8'd100);
    send_record(rec(8'd100, 8'd0, 64'd1, 32'd22, 1'b0));
    send_record(rec(8'd200, 8'd0, 64'd2, 32'd23, 1'b0));
    send_record(rec(8'd199, 8'd0, 64'd3, 32'd24, 1'b0));
    drain();

    set_filters(8'd0, 8'd0);
    random_phase(40);
    drain();

    set_filters(8'd16, 8'd5);
    quiet = 1'b1;
    random_phase(240);
    drain();
    quiet = 1'b0;

    set_filters(8'd255, 8'd0);
    random_phase(240);
    drain();

    set_filters(sgm_pkg::EV_W'($urandom_range(1, 254)),
                sgm_pkg::EV_W'($urandom_range(0, 255)));
    random_phase(280);
    drain();

    $display("%0d records over six filter settings, %0d outliers marked, %0d passed over",
             records, marks, skips);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
